[hdl/cml_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// cml_pkg
// Shared types and codes for the component membership lists: the input and
// result words, operation and status codes, and default sizes.
// ----------------------------------------------------------------------------
package cml_pkg;

  // default sizes
  localparam int DEF_LIST_DEPTH = 256;
  localparam int DEF_NUM_LISTS  = 9;

  // operation codes (any other code acts as a query)
  localparam logic [1:0] OP_ATTACH = 2'd0;
  localparam logic [1:0] OP_DETACH = 2'd1;
  localparam logic [1:0] OP_QUERY  = 2'd2;

  // status codes
  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_MISS    = 2'd2;
  localparam logic [1:0] ST_UNKNOWN = 2'd3;

  // input word
  typedef struct packed {
    logic [1:0]  operation;
    logic [3:0]  list_select;
    logic [15:0] object_id;
  } cml_in_t;

  // result word
  typedef struct packed {
    logic       success;
    logic [1:0] status;
  } cml_out_t;

endpackage
`default_nettype wire

[hdl/cml_list_engine.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// cml_list_engine
// Holds the list counts and the ID store. Attach writes one entry at the
// tail. Detach and query stream the list out of the store one entry a cycle;
// after the first match a detach writes each later entry back one place down.
// ----------------------------------------------------------------------------
module cml_list_engine
  import cml_pkg::*;
#(
  parameter int LIST_DEPTH = DEF_LIST_DEPTH,
  parameter int NUM_LISTS  = DEF_NUM_LISTS
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     req_valid,
  output logic          req_ready,
  input  wire cml_in_t  req,
  output logic          resp_valid,
  input  wire logic     resp_ready,
  output cml_out_t      resp
);

  localparam int CW        = $clog2(LIST_DEPTH);
  localparam int LW        = (NUM_LISTS > 1) ? $clog2(NUM_LISTS) : 1;
  localparam int AW        = LW + CW;
  localparam int MEM_DEPTH = NUM_LISTS * (1 << CW);

  // sequencer codes
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_WALK = 2'd1;
  localparam logic [1:0] S_RESP = 2'd2;

  logic [1:0]    state_r, state_nxt;
  logic          det_r, det_nxt;
  logic [LW-1:0] sel_r, sel_nxt;
  logic [15:0]   id_r, id_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] rd_idx_r, rd_idx_nxt;
  logic [CW-1:0] chk_idx_r, chk_idx_nxt;
  logic          rd_pend_r, rd_pend_nxt;
  logic          found_r, found_nxt;
  cml_out_t      res_r, res_nxt;

  logic [CW-1:0] counts_r [NUM_LISTS];
  logic [15:0]   mem [MEM_DEPTH];
  logic [15:0]   rd_data_r;

  logic          req_sel_ok;
  logic [LW-1:0] req_sel;
  logic [CW-1:0] req_cnt;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [15:0]   mem_wdata;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;
  logic          cnt_we;
  logic [LW-1:0] cnt_wsel;
  logic [CW-1:0] cnt_wval;
  logic          hit;
  logic          last;

  // request decode
  assign req_sel_ok = {1'b0, req.list_select} < 5'(NUM_LISTS);
  assign req_sel    = req.list_select[LW-1:0];
  assign req_cnt    = counts_r[req_sel];

  assign hit  = rd_data_r == id_r;
  assign last = chk_idx_r == (cnt_r - 1'b1);

  assign req_ready  = state_r == S_IDLE;
  assign resp_valid = state_r == S_RESP;
  assign resp       = res_r;

  // sequencer
  always_comb begin
    state_nxt   = state_r;
    det_nxt     = det_r;
    sel_nxt     = sel_r;
    id_nxt      = id_r;
    cnt_nxt     = cnt_r;
    rd_idx_nxt  = rd_idx_r;
    chk_idx_nxt = chk_idx_r;
    rd_pend_nxt = 1'b0;
    found_nxt   = found_r;
    res_nxt     = res_r;
    mem_we      = 1'b0;
    mem_waddr   = {sel_r, chk_idx_r - 1'b1};
    mem_wdata   = rd_data_r;
    mem_re      = 1'b0;
    mem_raddr   = {sel_r, rd_idx_r};
    cnt_we      = 1'b0;
    cnt_wsel    = sel_r;
    cnt_wval    = cnt_r - 1'b1;
    case (state_r)
      S_IDLE: begin
        if (req_valid) begin
          det_nxt    = req.operation == OP_DETACH;
          sel_nxt    = req_sel;
          id_nxt     = req.object_id;
          cnt_nxt    = req_cnt;
          rd_idx_nxt = '0;
          found_nxt  = 1'b0;
          state_nxt  = S_RESP;
          res_nxt    = '{success: 1'b0, status: ST_DONE};
          if (!req_sel_ok) begin
            res_nxt.status = ST_UNKNOWN;
          end else if (req.operation == OP_ATTACH) begin
            if (req_cnt == CW'(LIST_DEPTH - 1)) begin
              res_nxt.status = ST_FULL;
            end else begin
              // append at the tail
              mem_we          = 1'b1;
              mem_waddr       = {req_sel, req_cnt};
              mem_wdata       = req.object_id;
              cnt_we          = 1'b1;
              cnt_wsel        = req_sel;
              cnt_wval        = req_cnt + 1'b1;
              res_nxt.success = 1'b1;
            end
          end else if (req_cnt == '0) begin
            res_nxt.status = ST_MISS;
          end else begin
            state_nxt = S_WALK;
          end
        end
      end
      S_WALK: begin
        // issue the next read
        if (rd_idx_r < cnt_r) begin
          mem_re      = 1'b1;
          rd_pend_nxt = 1'b1;
          chk_idx_nxt = rd_idx_r;
          rd_idx_nxt  = rd_idx_r + 1'b1;
        end
        // check the returning word
        if (rd_pend_r) begin
          if (!found_r && hit) begin
            found_nxt = 1'b1;
          end else if (found_r && det_r) begin
            mem_we = 1'b1;
          end
          if (last) begin
            state_nxt   = S_RESP;
            rd_pend_nxt = 1'b0;
            res_nxt     = found_nxt ? cml_out_t'{success: 1'b1, status: ST_DONE}
                                    : cml_out_t'{success: 1'b0, status: ST_MISS};
            if (found_nxt && det_r) begin
              cnt_we = 1'b1;
            end
          end
        end
      end
      S_RESP: begin
        if (resp_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      rd_pend_r <= 1'b0;
      for (int i = 0; i < NUM_LISTS; i++) begin
        counts_r[i] <= '0;
      end
    end else begin
      state_r   <= state_nxt;
      rd_pend_r <= rd_pend_nxt;
      if (cnt_we) begin
        counts_r[cnt_wsel] <= cnt_wval;
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    det_r     <= det_nxt;
    sel_r     <= sel_nxt;
    id_r      <= id_nxt;
    cnt_r     <= cnt_nxt;
    rd_idx_r  <= rd_idx_nxt;
    chk_idx_r <= chk_idx_nxt;
    found_r   <= found_nxt;
    res_r     <= res_nxt;
  end

  // id store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= mem[mem_raddr];
    end
  end

endmodule
`default_nettype wire

[hdl/component_membership_lists.sv]
`default_nettype none
// Attach, unknown list and empty list pass from the idle state through the
// response state to the output register; detach and query first walk the list,
// reading each entry through the single read port of the id store. No new
// word is taken while the engine is busy. Reset empties every list at once.
// ----------------------------------------------------------------------------
// component_membership_lists
// Keeps ordered lists of object IDs, one per component kind, with attach,
// detach and query operations and an output register towards the consumer.
// ----------------------------------------------------------------------------
module component_membership_lists
  import cml_pkg::*;
#(
  parameter int LIST_DEPTH = DEF_LIST_DEPTH,
  parameter int NUM_LISTS  = DEF_NUM_LISTS
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  output logic         in_stall,
  input  wire cml_in_t in_data,
  output logic         out_valid,
  input  wire logic    out_stall,
  output cml_out_t     out_data
);

  logic     eng_ready;
  logic     eng_resp_valid;
  logic     eng_resp_ready;
  cml_out_t eng_resp;
  logic     out_valid_r, out_valid_nxt;
  cml_out_t out_data_r;

  // input side
  assign in_stall = !eng_ready;

  cml_list_engine #(
    .LIST_DEPTH (LIST_DEPTH),
    .NUM_LISTS  (NUM_LISTS)
  ) u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (in_valid),
    .req_ready  (eng_ready),
    .req        (in_data),
    .resp_valid (eng_resp_valid),
    .resp_ready (eng_resp_ready),
    .resp       (eng_resp)
  );

  // output register
  assign eng_resp_ready = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (eng_resp_valid && eng_resp_ready) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (eng_resp_valid && eng_resp_ready) begin
      out_data_r <= eng_resp;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

[bench/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives attach, detach and query words into component_membership_lists and
// checks every result word against a software copy of the nine ID lists. A
// short directed table covers reset, unknown lists, duplicates, the spare
// operation code and empty lists; random words then follow, with one list
// filled to its limit, random idling on both sides and one long consumer
// hold-off per phase.
// ----------------------------------------------------------------------------
module testbench;
  import cml_pkg::*;

  localparam int LIST_DEPTH  = DEF_LIST_DEPTH;
  localparam int NUM_LISTS   = DEF_NUM_LISTS;
  localparam int HOLD_CYCLES = 300;
  localparam int DIR_ROWS    = 25;
  localparam int TIMEOUT_NS  = 12_000_000;
  localparam int MAX_REPORTS = 10;

  // code three is not named in the package; the block decodes it as a query
  localparam logic [1:0] OP_SPARE = 2'd3;

  // one row of the directed table: word, whether the result is fixed, result
  typedef struct packed {
    cml_in_t  word;
    logic     fixed;
    cml_out_t want;
  } stim_row_t;

  logic     clk = 1'b0;
  logic     rst_n;
  logic     in_valid;
  logic     in_stall;
  cml_in_t  in_data;
  logic     out_valid;
  logic     out_stall;
  cml_out_t out_data;

  // software copy of the lists
  logic [15:0] id_store [NUM_LISTS][LIST_DEPTH];
  int          entry_count [NUM_LISTS];

  cml_out_t  pending_results [$];
  stim_row_t directed_rows [0:DIR_ROWS-1];
  int        mismatches = 0;
  int        gap_pct    = 0;
  int        stall_pct  = 0;
  bit        hold_req   = 1'b0;

  component_membership_lists dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #5 clk = ~clk;

  // list operation on the software copy, returns the result word
  function automatic cml_out_t apply_list_op(input cml_in_t w);
    cml_out_t r;
    int       s;
    int       n;
    int       pos;
    r.success = 1'b0;
    r.status  = ST_DONE;
    s = w.list_select;
    if (s >= NUM_LISTS) begin
      r.status = ST_UNKNOWN;
    end else begin
      n = entry_count[s];
      if (w.operation == OP_ATTACH) begin
        if (n + 1 >= LIST_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          id_store[s][n] = w.object_id;
          entry_count[s] = n + 1;
          r.success = 1'b1;
        end
      end else begin
        // first match, or n when absent
        pos = n;
        for (int i = 0; i < n; i++) begin
          if (id_store[s][i] == w.object_id) begin
            pos = i;
            break;
          end
        end
        if (pos >= n) begin
          r.status = ST_MISS;
        end else begin
          r.success = 1'b1;
          if (w.operation == OP_DETACH) begin
            for (int i = pos; i + 1 < n; i++) id_store[s][i] = id_store[s][i + 1];
            entry_count[s] = n - 1;
          end
        end
      end
    end
    return r;
  endfunction

  // random word, mostly aimed at IDs already held so that walks hit
  function automatic cml_in_t pick_word();
    cml_in_t w;
    int      roll;
    int      s;
    roll = $urandom_range(99);
    s = $urandom_range(NUM_LISTS - 1);
    if ($urandom_range(99) < 6) s = $urandom_range(15, NUM_LISTS);
    w.list_select = 4'(s);
    if (roll < 42) w.operation = OP_ATTACH;
    else if (roll < 72) w.operation = OP_DETACH;
    else if (roll < 95) w.operation = OP_QUERY;
    else w.operation = OP_SPARE;
    // small pool gives duplicates, full range covers every bit
    if ($urandom_range(1) == 1) w.object_id = 16'($urandom_range(15));
    else w.object_id = 16'($urandom);
    if (w.operation != OP_ATTACH && s < NUM_LISTS && entry_count[s] > 0 &&
        $urandom_range(99) < 70)
      w.object_id = id_store[s][$urandom_range(entry_count[s] - 1)];
    return w;
  endfunction

  // offer one word, predict its result once it is taken
  task automatic offer_word(input cml_in_t w, input bit fixed, input cml_out_t want);
    cml_out_t r;
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      in_data  <= cml_in_t'($urandom);
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (in_stall);
    r = apply_list_op(w);
    pending_results.push_back(fixed ? want : r);
    @(negedge clk);
  endtask

  // consumer: random stalls, plus a long hold-off on request
  initial begin : consumer
    int hold_left;
    hold_left = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  // result check against the oldest expectation
  always @(posedge clk) begin : result_check
    cml_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected result word: success %0b status %0d",
                   out_data.success, out_data.status);
      end else begin
        want = pending_results.pop_front();
        if (out_data.success !== want.success || out_data.status !== want.status) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("mismatch: expected success %0b status %0d, got success %0b status %0d",
                     want.success, want.status, out_data.success, out_data.status);
        end
      end
    end
  end

  // run limit
  initial begin
    #(TIMEOUT_NS);
    $display("testbench failed");
    $finish;
  end

  // stimulus
  initial begin : stimulus
    cml_in_t w;
    int      sel_full;
    int      n_fill;
    int      n_rand;
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;

    // directed rows; fixed results only where obvious
    directed_rows = '{
      {OP_QUERY,  4'd0,  16'h0000, 1'b1, 1'b0, ST_MISS},
      {OP_DETACH, 4'd0,  16'h0000, 1'b1, 1'b0, ST_MISS},
      {OP_ATTACH, 4'd9,  16'h0000, 1'b1, 1'b0, ST_UNKNOWN},
      {OP_DETACH, 4'd15, 16'hFFFF, 1'b1, 1'b0, ST_UNKNOWN},
      {OP_QUERY,  4'd12, 16'h0000, 1'b1, 1'b0, ST_UNKNOWN},
      {OP_SPARE,  4'd10, 16'hFFFF, 1'b1, 1'b0, ST_UNKNOWN},
      {OP_ATTACH, 4'd0,  16'h0000, 1'b1, 1'b1, ST_DONE},
      {OP_ATTACH, 4'd0,  16'hFFFF, 1'b1, 1'b1, ST_DONE},
      {OP_ATTACH, 4'd0,  16'hFFFF, 1'b1, 1'b1, ST_DONE},
      {OP_ATTACH, 4'd0,  16'h8000, 1'b0, 1'b0, ST_DONE},
      {OP_QUERY,  4'd0,  16'hFFFF, 1'b1, 1'b1, ST_DONE},
      {OP_DETACH, 4'd0,  16'hFFFF, 1'b0, 1'b0, ST_DONE},
      {OP_QUERY,  4'd0,  16'hFFFF, 1'b0, 1'b0, ST_DONE},
      {OP_DETACH, 4'd0,  16'hFFFF, 1'b0, 1'b0, ST_DONE},
      {OP_QUERY,  4'd0,  16'hFFFF, 1'b0, 1'b0, ST_DONE},
      {OP_DETACH, 4'd0,  16'h1234, 1'b0, 1'b0, ST_DONE},
      {OP_SPARE,  4'd0,  16'h0000, 1'b0, 1'b0, ST_DONE},
      {OP_SPARE,  4'd0,  16'h7FFF, 1'b0, 1'b0, ST_DONE},
      {OP_ATTACH, 4'd8,  16'hAAAA, 1'b1, 1'b1, ST_DONE},
      {OP_ATTACH, 4'd8,  16'h5555, 1'b0, 1'b0, ST_DONE},
      {OP_DETACH, 4'd8,  16'hAAAA, 1'b0, 1'b0, ST_DONE},
      {OP_QUERY,  4'd8,  16'h5555, 1'b0, 1'b0, ST_DONE},
      {OP_DETACH, 4'd8,  16'h5555, 1'b0, 1'b0, ST_DONE},
      {OP_DETACH, 4'd8,  16'h5555, 1'b0, 1'b0, ST_DONE},
      {OP_QUERY,  4'd8,  16'h0001, 1'b0, 1'b0, ST_DONE}
    };

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int phase = 0; phase < 3; phase++) begin
      // idling mix per phase
      case (phase)
        0: begin
          gap_pct   = 21;
          stall_pct = 74;
        end
        1: begin
          gap_pct   = 74;
          stall_pct = 21;
        end
        default: begin
          gap_pct   = 0;
          stall_pct = 0;
        end
      endcase

      if (phase == 0) begin
        for (int i = 0; i < DIR_ROWS; i++)
          offer_word(directed_rows[i].word, directed_rows[i].fixed, directed_rows[i].want);
      end

      // long consumer hold-off while words keep coming
      hold_req = 1'b1;

      if (phase == 1) begin
        // fill one list past its limit, then long walks on it
        sel_full = $urandom_range(NUM_LISTS - 1);
        n_fill = (LIST_DEPTH - 1 - entry_count[sel_full]) + 3;
        w.operation   = OP_ATTACH;
        w.list_select = 4'(sel_full);
        repeat (n_fill) begin
          w.object_id = 16'($urandom);
          offer_word(w, 1'b0, '0);
        end
        w.operation = OP_QUERY;
        w.object_id = 16'($urandom);
        offer_word(w, 1'b0, '0);
        w.operation = OP_DETACH;
        w.object_id = id_store[sel_full][entry_count[sel_full] - 1];
        offer_word(w, 1'b0, '0);
        w.object_id = id_store[sel_full][0];
        offer_word(w, 1'b0, '0);
        w.operation = OP_ATTACH;
        w.object_id = 16'($urandom);
        offer_word(w, 1'b0, '0);
        offer_word(w, 1'b0, '0);
        n_rand = 120;
      end else begin
        n_rand = 330;
      end

      repeat (n_rand) offer_word(pick_word(), 1'b0, '0);
    end

    // drain
    in_valid <= 1'b0;
    wait (pending_results.size() == 0);
    repeat (LIST_DEPTH + 8) @(posedge clk);
    if (mismatches == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

[filelist.f]
hdl/cml_pkg.sv
hdl/cml_list_engine.sv
hdl/component_membership_lists.sv
bench/testbench.sv
